// ===== rtl/swk_pkg.sv =====
// ----------------------------------------------------------------------------
// swk_pkg
// Shared types, constants and tables of the swerve wheel kinematics block.
// ----------------------------------------------------------------------------
package swk_pkg;

  localparam int unsigned WHEEL_COUNT_DEF  = 4;
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_LEN         = 24;

  localparam logic [15:0] OFFSET_RESET = 16'd34013;
  localparam logic [15:0] INV_RAD_RESET = 16'd5120;
  localparam logic [23:0] INV_GAIN_Q24 = 24'd10188014;

  localparam logic signed [14:0] ANGLE_MAX = 15'sd12868;
  localparam logic signed [14:0] ANGLE_MIN = -15'sd12867;
  localparam logic signed [22:0] SPEED_MAX = 23'sd4194303;
  localparam logic signed [22:0] SPEED_MIN = -23'sd4194304;

  typedef enum logic [2:0] {
    CFG_WHEEL_OFFSET = 3'd0,
    CFG_INV_RADIUS   = 3'd1,
    CFG_INVERT_X     = 3'd2,
    CFG_INVERT_Y     = 3'd3,
    CFG_INVERT_Z     = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_SETUP,
    ST_ROT,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_FIN,
    ST_OUT
  } state_t;

  // round(atan(2^-i) * 2^24)
  function automatic logic [23:0] atan_q24(input logic [4:0] idx);
    logic [23:0] v;
    unique case (idx)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047214;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262123;
      5'd7:  v = 24'd131069;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      5'd20: v = 24'd16;
      5'd21: v = 24'd8;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/swk_ifs.sv =====
// ----------------------------------------------------------------------------
// swk_ifs
// Request and result channels of the swerve wheel kinematics block.
// ----------------------------------------------------------------------------
interface swk_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] rot_z;
  modport source (output valid, output vel_x, output vel_y, output rot_z, input ready);
  modport sink   (input valid, input vel_x, input vel_y, input rot_z, output ready);
endinterface

interface swk_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         wheel_index;
  logic signed [22:0] wheel_speed;
  logic signed [14:0] steer_angle;
  logic               last_wheel;
  modport source (output valid, output wheel_index, output wheel_speed,
                  output steer_angle, output last_wheel, input ready);
  modport sink   (input valid, input wheel_index, input wheel_speed,
                  input steer_angle, input last_wheel, output ready);
endinterface

// ===== rtl/swerve_wheel_kinematics.sv =====
// ----------------------------------------------------------------------------
// swerve_wheel_kinematics
// Four-wheel swerve inverse kinematics: per-wheel heading and wheel speed
// from one body velocity request, using one shared CORDIC and a shared scaling multiplier.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  in_chan   sink       vel_x, vel_y, rot_z (Q4.12)
//  out_chan  source     wheel_index, wheel_speed, steer_angle, last_wheel
//  cfg_*     write      cfg_addr selects the register, cfg_wdata is the value
//
// A request passes ST_PROD once, then per wheel ST_SETUP, the CORDIC ST_ROT
// steps, ST_MUL0 to ST_MUL3, ST_FIN and ST_OUT; a wheel with zero ground
// velocity goes from ST_SETUP straight to ST_OUT, skipping the rotate unit.
// Stalls on out_chan hold the sequencer; in_chan is ready only when idle.
// Reset is synchronous; it loads the config registers with their reset values and clears the held headings.
// ----------------------------------------------------------------------------
module swerve_wheel_kinematics #(
  parameter int unsigned CORDIC_STEPS = swk_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  swk_in_if.sink      in_chan,
  swk_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  swk_pkg::state_t state_r, state_nxt;

  logic [15:0]        offs_r, irw_r;
  logic               inv_x_r, inv_y_r, inv_z_r;
  logic signed [16:0] vx_r, vy_r, wz_r;
  logic signed [33:0] t_r;
  logic signed [35:0] x_r, y_r;
  logic signed [26:0] z_r;
  logic [4:0]         step_r;
  logic [1:0]         wheel_r;
  logic               flip_r;
  logic [58:0]        acc_r;
  logic [33:0]        mag_r;
  logic signed [14:0] held_r [4];
  logic [1:0]         o_idx_r;
  logic signed [22:0] o_spd_r;
  logic signed [14:0] o_ang_r;

  logic [17:0] mul_a;
  logic [23:0] mul_b;
  logic [41:0] prod;

  logic signed [35:0] xs, ys;
  logic signed [35:0] dx, dy;
  logic [58:0]        sum;
  logic signed [27:0] spd;
  logic signed [15:0] ang;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swk_pkg::ST_IDLE:  if (in_chan.valid) state_nxt = swk_pkg::ST_PROD;
      swk_pkg::ST_PROD:  state_nxt = swk_pkg::ST_SETUP;
      swk_pkg::ST_SETUP: state_nxt = (xs == '0 && ys == '0) ? swk_pkg::ST_OUT
                                                          : swk_pkg::ST_ROT;
      swk_pkg::ST_ROT:   if (step_r == LAST_STEP) state_nxt = swk_pkg::ST_MUL0;
      swk_pkg::ST_MUL0:  state_nxt = swk_pkg::ST_MUL1;
      swk_pkg::ST_MUL1:  state_nxt = swk_pkg::ST_MUL2;
      swk_pkg::ST_MUL2:  state_nxt = swk_pkg::ST_MUL3;
      swk_pkg::ST_MUL3:  state_nxt = swk_pkg::ST_FIN;
      swk_pkg::ST_FIN:   state_nxt = swk_pkg::ST_OUT;
      swk_pkg::ST_OUT: begin
        if (out_chan.ready)
          state_nxt = (wheel_r == 2'd3) ? swk_pkg::ST_IDLE : swk_pkg::ST_SETUP;
      end
      default: state_nxt = swk_pkg::ST_IDLE;
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = x_r[17:0];
    mul_b = swk_pkg::INV_GAIN_Q24;
    unique case (state_r)
      swk_pkg::ST_MUL1: mul_a = x_r[35:18];
      swk_pkg::ST_MUL2: begin
        mul_a = mag_r[17:0];
        mul_b = {8'd0, irw_r};
      end
      swk_pkg::ST_MUL3: begin
        mul_a = {2'd0, mag_r[33:18]};
        mul_b = {8'd0, irw_r};
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;
  assign sum  = acc_r + {prod[40:0], 18'd0};

  // Wheel ground velocity: the rotation term t = wz * a changes sign per corner.
  assign xs = ($signed({{3{vx_r[16]}}, vx_r, 16'd0}))
            + ((wheel_r[1] == wheel_r[0]) ? 36'(t_r) : -36'(t_r));
  assign ys = ($signed({{3{vy_r[16]}}, vy_r, 16'd0}))
            + (wheel_r[1] ? -36'(t_r) : 36'(t_r));

  assign dx = y_r >>> step_r;
  assign dy = x_r >>> step_r;

  assign spd = flip_r ? -$signed({1'b0, acc_r[50:24]}) : $signed({1'b0, acc_r[50:24]});
  assign ang = 16'((z_r + 27'sd1024) >>> 11);

  assign in_chan.ready        = (state_r == swk_pkg::ST_IDLE);
  assign out_chan.valid       = (state_r == swk_pkg::ST_OUT);
  assign out_chan.wheel_index = o_idx_r;
  assign out_chan.wheel_speed = o_spd_r;
  assign out_chan.steer_angle = o_ang_r;
  assign out_chan.last_wheel  = (o_idx_r == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swk_pkg::ST_IDLE;
      offs_r  <= swk_pkg::OFFSET_RESET;
      irw_r   <= swk_pkg::INV_RAD_RESET;
      inv_x_r <= 1'b0;
      inv_y_r <= 1'b0;
      inv_z_r <= 1'b0;
      wheel_r <= 2'd0;
      for (int i = 0; i < 4; i++) held_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          swk_pkg::CFG_WHEEL_OFFSET: offs_r  <= cfg_wdata;
          swk_pkg::CFG_INV_RADIUS:   irw_r   <= cfg_wdata;
          swk_pkg::CFG_INVERT_X:     inv_x_r <= cfg_wdata[0];
          swk_pkg::CFG_INVERT_Y:     inv_y_r <= cfg_wdata[0];
          swk_pkg::CFG_INVERT_Z:     inv_z_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      unique case (state_r)
        swk_pkg::ST_IDLE: begin
          wheel_r <= 2'd0;
          vx_r <= inv_x_r ? -17'(in_chan.vel_x) : 17'(in_chan.vel_x);
          vy_r <= inv_y_r ? -17'(in_chan.vel_y) : 17'(in_chan.vel_y);
          wz_r <= inv_z_r ? -17'(in_chan.rot_z) : 17'(in_chan.rot_z);
        end
        swk_pkg::ST_PROD: t_r <= wz_r * $signed({1'b0, offs_r});
        swk_pkg::ST_SETUP: begin
          o_idx_r <= wheel_r;
          o_spd_r <= '0;
          o_ang_r <= held_r[wheel_r];
          // Vectors in the left half plane, or on the negative y axis, are negated into the right one.
          flip_r  <= xs[35] || (xs == '0 && ys[35]);
          x_r     <= (xs[35] || (xs == '0 && ys[35])) ? -xs : xs;
          y_r     <= (xs[35] || (xs == '0 && ys[35])) ? -ys : ys;
          z_r     <= '0;
          step_r  <= '0;
        end
        swk_pkg::ST_ROT: begin
          step_r <= step_r + 5'd1;
          if (y_r > 0) begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + $signed({3'd0, swk_pkg::atan_q24(step_r)});
          end else begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - $signed({3'd0, swk_pkg::atan_q24(step_r)});
          end
        end
        swk_pkg::ST_MUL0: acc_r <= 59'(prod);
        swk_pkg::ST_MUL1: mag_r <= sum[57:24];
        swk_pkg::ST_MUL2: acc_r <= 59'(prod) + 59'(24'h800000);
        swk_pkg::ST_MUL3: acc_r <= sum;
        swk_pkg::ST_FIN: begin
          if (spd > 28'(swk_pkg::SPEED_MAX))      o_spd_r <= swk_pkg::SPEED_MAX;
          else if (spd < 28'(swk_pkg::SPEED_MIN)) o_spd_r <= swk_pkg::SPEED_MIN;
          else                                    o_spd_r <= spd[22:0];
          if (ang > 16'(swk_pkg::ANGLE_MAX)) begin
            o_ang_r         <= swk_pkg::ANGLE_MAX;
            held_r[wheel_r] <= swk_pkg::ANGLE_MAX;
          end else if (ang < 16'(swk_pkg::ANGLE_MIN)) begin
            o_ang_r         <= swk_pkg::ANGLE_MIN;
            held_r[wheel_r] <= swk_pkg::ANGLE_MIN;
          end else begin
            o_ang_r         <= ang[14:0];
            held_r[wheel_r] <= ang[14:0];
          end
        end
        swk_pkg::ST_OUT: if (out_chan.ready) wheel_r <= wheel_r + 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// ===== sim/tb_swerve_wheel_kinematics.sv =====
// ----------------------------------------------------------------------------
// tb_swerve_wheel_kinematics
// Self-checking bench for the swerve wheel kinematics block. Velocity requests
// go in on one channel and a local predictor works out the four expected wheel
// results; every result is checked field by field in order. The registers are
// changed between phases, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb_swerve_wheel_kinematics;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]         idx;
    logic signed [22:0] speed;
    logic signed [14:0] angle;
    logic               last;
  } wheel_cmd_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  swk_in_if  in_chan();
  swk_out_if out_chan();

  swerve_wheel_kinematics u_top (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Predictor state and register copies.
  logic [15:0]        half_track;
  logic [15:0]        inv_radius;
  logic               flip_x, flip_y, flip_z;
  logic signed [14:0] heading_hold [4];

  wheel_cmd_t wheel_queue [$];
  int         err_count;
  int         wheels_seen;
  int         requests_sent;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl [24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                         262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                         1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
    return tbl[i];
  endfunction

  task automatic predict_wheels(logic signed [15:0] vx_in, logic signed [15:0] vy_in,
                                logic signed [15:0] wz_in);
    longint vx, vy, wz, px, py, x, y, z, dx, dy, mag, spd;
    longint sx [4] = '{1, 1, -1, -1};
    longint sy [4] = '{-1, 1, 1, -1};
    logic   flip;
    wheel_cmd_t r;
    vx = vx_in;
    vy = vy_in;
    wz = wz_in;
    if (flip_x) vx = -vx;
    if (flip_y) vy = -vy;
    if (flip_z) wz = -wz;
    for (int w = 0; w < 4; w++) begin
      px = longint'(half_track) * sx[w];
      py = longint'(half_track) * sy[w];
      x = vx * 65536 - wz * py;
      y = vy * 65536 + wz * px;
      r.idx = w[1:0];
      r.last = (w == 3);
      if (x == 0 && y == 0) begin
        r.speed = '0;
        r.angle = heading_hold[w];
      end else begin
        flip = (x < 0) || (x == 0 && y < 0);
        z = 0;
        if (flip) begin
          x = -x;
          y = -y;
        end
        for (int i = 0; i < swk_pkg::CORDIC_STEPS_DEF; i++) begin
          dx = floor_shr(y, i);
          dy = floor_shr(x, i);
          if (y > 0) begin
            x += dx; y -= dy; z += atan_entry(i);
          end else begin
            x -= dx; y += dy; z -= atan_entry(i);
          end
        end
        mag = (x * 10188014) >>> 24;
        spd = (mag * longint'(inv_radius) + (longint'(1) << 23)) >>> 24;
        if (flip) spd = -spd;
        if (spd > 4194303) spd = 4194303;
        if (spd < -4194304) spd = -4194304;
        z = floor_shr(z + 1024, 11);
        if (z > 12868) z = 12868;
        if (z < -12867) z = -12867;
        r.speed = spd[22:0];
        r.angle = z[14:0];
        heading_hold[w] = z[14:0];
      end
      wheel_queue.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // Result checker and receiver idling.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      wheels_seen++;
      if (wheel_queue.size() == 0) begin
        report_mismatch("unexpected result", out_chan.wheel_index, -1);
      end else begin
        wheel_cmd_t e;
        e = wheel_queue.pop_front();
        if (out_chan.wheel_index !== e.idx)
          report_mismatch("wheel_index", out_chan.wheel_index, e.idx);
        if (out_chan.wheel_speed !== e.speed)
          report_mismatch("wheel_speed", out_chan.wheel_speed, e.speed);
        if (out_chan.steer_angle !== e.angle)
          report_mismatch("steer_angle", out_chan.steer_angle, e.angle);
        if (out_chan.last_wheel !== e.last)
          report_mismatch("last_wheel", out_chan.last_wheel, e.last);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(swk_pkg::cfg_index_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      swk_pkg::CFG_WHEEL_OFFSET: half_track = val;
      swk_pkg::CFG_INV_RADIUS:   inv_radius = val;
      swk_pkg::CFG_INVERT_X:     flip_x = val[0];
      swk_pkg::CFG_INVERT_Y:     flip_y = val[0];
      swk_pkg::CFG_INVERT_Z:     flip_z = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // The request stays valid after acceptance until the next idle cycle or the
  // next request, so that valid changes at most once per edge.
  task automatic send_request(logic [15:0] vx, logic [15:0] vy, logic [15:0] wz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.vel_x <= vx;
    in_chan.vel_y <= vy;
    in_chan.rot_z <= wz;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_wheels(vx, vy, wz);
    requests_sent++;
  endtask

  // Waits out the results and a margin, so registers can change safely.
  task automatic drain;
    int guard;
    guard = 0;
    in_chan.valid <= 1'b0;
    while (wheel_queue.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (120) @(posedge clk);
  endtask

  task automatic send_random(int n);
    logic [15:0] vx, vy, wz;
    for (int i = 0; i < n; i++) begin
      vx = 16'($urandom);
      vy = 16'($urandom);
      wz = 16'($urandom);
      case ($urandom_range(5))
        0: vx = '0;
        1: wz = '0;
        2: begin
          vx = 16'($urandom_range(255)) - 16'd128;
          vy = 16'($urandom_range(255)) - 16'd128;
          wz = 16'($urandom_range(255)) - 16'd128;
        end
        default: ;
      endcase
      send_request(vx, vy, wz);
    end
  endtask

  task automatic test_directed;
    send_request(16'h0000, 16'h0000, 16'h0000);  // zero vector holds reset heading
    send_request(16'h7FFF, 16'h0000, 16'h0000);
    send_request(16'h8000, 16'h0000, 16'h0000);  // negative x axis
    send_request(16'h0000, 16'h7FFF, 16'h0000);
    send_request(16'h0000, 16'h8000, 16'h0000);  // x zero, y negative
    send_request(16'h0000, 16'h0000, 16'h7FFF);
    send_request(16'h0000, 16'h0000, 16'h8000);
    send_request(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_request(16'h8000, 16'h8000, 16'h8000);
    send_request(16'h0000, 16'h0000, 16'h0000);  // headings held from before
    send_request(16'h0001, 16'hFFFF, 16'h0001);
    send_request(16'h1000, 16'h1000, 16'h0000);
    send_request(16'hF000, 16'h1000, 16'h0000);
    // With a zero offset, rotation gives no wheel motion.
    drain();
    write_reg(swk_pkg::CFG_WHEEL_OFFSET, 16'h0000);
    send_request(16'h0000, 16'h0000, 16'h7FFF);
    send_request(16'h8000, 16'h8000, 16'h1234);
    drain();
  endtask

  task automatic test_inversions;
    write_reg(swk_pkg::CFG_WHEEL_OFFSET, 16'hFFFF);
    write_reg(swk_pkg::CFG_INV_RADIUS, 16'hFFFF);
    write_reg(swk_pkg::CFG_INVERT_X, 16'h0001);
    write_reg(swk_pkg::CFG_INVERT_Y, 16'h0001);
    write_reg(swk_pkg::CFG_INVERT_Z, 16'h0001);
    // Negating the most negative value must not saturate.
    send_request(16'h8000, 16'h8000, 16'h8000);
    send_request(16'h7FFF, 16'h8000, 16'h0000);
    send_random(30);
    drain();
    write_reg(swk_pkg::CFG_INV_RADIUS, 16'h0000);
    write_reg(swk_pkg::CFG_INVERT_Y, 16'h0000);
    send_random(20);
    drain();
  endtask

  task automatic test_random_settings(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_reg(swk_pkg::CFG_WHEEL_OFFSET,
                ($urandom_range(3) == 0) ? 16'(34013) : 16'($urandom));
      write_reg(swk_pkg::CFG_INV_RADIUS,
                ($urandom_range(3) == 0) ? 16'(5120) : 16'($urandom));
      write_reg(swk_pkg::CFG_INVERT_X, 16'($urandom_range(1)));
      write_reg(swk_pkg::CFG_INVERT_Y, 16'($urandom_range(1)));
      write_reg(swk_pkg::CFG_INVERT_Z, 16'($urandom_range(1)));
      send_random(per_phase);
      drain();
    end
  endtask

  // Receiver holds off long enough for the sender to be stalled at the input.
  task automatic test_backpressure;
    hold_cycles = 600;
    send_random(12);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = swk_pkg::CFG_WHEEL_OFFSET;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.vel_x = '0;
    in_chan.vel_y = '0;
    in_chan.rot_z = '0;
    out_chan.ready = 1'b0;
    hold_cycles = 0;
    err_count = 0;
    wheels_seen = 0;
    requests_sent = 0;
    half_track = swk_pkg::OFFSET_RESET;
    inv_radius = swk_pkg::INV_RAD_RESET;
    flip_x = 1'b0;
    flip_y = 1'b0;
    flip_z = 1'b0;
    for (int i = 0; i < 4; i++) heading_hold[i] = '0;
    send_idle_pct = 7;
    recv_idle_pct = 50;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_inversions();
    test_random_settings(4, 30);
    send_idle_pct = 50;
    recv_idle_pct = 7;
    test_random_settings(4, 30);
    test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_settings(5, 40);
    drain();

    $display("Covered %0d requests and %0d wheel results over extreme, default and",
             requests_sent, wheels_seen);
    $display("random register settings, with idling and a long output stall.");
    if (err_count == 0 && wheel_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
